### hw/rtl/postfix_expression_evaluator_macros.svh
// assertion macros shared by the evaluator rtl
// each macro expects clk and rst in scope
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH

// condition holds at every edge out of reset
`define PEV_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PEV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define PEV_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/pev_pkg.sv
package pev_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  // field widths
  localparam int DATA_W = 32;
  localparam int KIND_W = 3;
  localparam int STAT_W = 3;
  localparam int FRAC_W = 16;

  // iteration counts of the shared unit
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(DATA_W);
  localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(DATA_W + 1);

  // token kinds
  localparam logic [KIND_W-1:0] KIND_OPERAND = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MUL     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DIV     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ADD     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SUB     = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_SHORT   = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNDER   = 3'd2;
  localparam logic [STAT_W-1:0] ST_LEFT    = 3'd3;
  localparam logic [STAT_W-1:0] ST_BADTOK  = 3'd4;
  localparam logic [STAT_W-1:0] ST_DIVZERO = 3'd5;
  localparam logic [STAT_W-1:0] ST_OVER    = 3'd6;

  // expression length check
  localparam logic [1:0] MIN_TOKENS = 2'd3;

  // saturation limits
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // request to the arithmetic unit
  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;
  } alu_req_t;

  // answer from the arithmetic unit
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

### hw/rtl/pev_ram.sv
module pev_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/pev_alu.sv
module pev_alu
  import pev_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  state_t            state;
  alu_op_t           op;
  logic              neg;
  logic              ovf;
  logic [STEP_W-1:0] cnt;
  logic [DATA_W-1:0] mc;
  logic [DATA_W-1:0] acc_hi;
  logic [DATA_W-1:0] acc_lo;
  logic [DATA_W-1:0] rem;
  logic [DATA_W:0]   dv;
  logic [DATA_W:0]   quo;
  logic              done;
  logic [DATA_W-1:0] result;

  logic [DATA_W-1:0] l_mag;
  logic [DATA_W-1:0] r_mag;
  logic              div_big;
  logic [DATA_W+1:0] opa;
  logic [DATA_W+1:0] opb;
  logic              sub;
  logic [DATA_W+1:0] sum;
  logic [DATA_W-1:0] addsub_res;
  logic [2*DATA_W:0] prod;
  logic [DATA_W+FRAC_W:0] prod_q;
  logic [DATA_W-1:0] mul_res;
  logic [DATA_W-1:0] div_res;

  // operand magnitudes
  assign l_mag = req.left[DATA_W-1]  ? (~req.left + DATA_W'(1))  : req.left;
  assign r_mag = req.right[DATA_W-1] ? (~req.right + DATA_W'(1)) : req.right;

  // quotient of 2**33 or more saturates without iterating
  assign div_big = {{(FRAC_W+1){1'b0}}, l_mag} >= {r_mag, {(FRAC_W+1){1'b0}}};

  // shared adder: multiply step, divide step, or add/sub
  always_comb begin
    case (state)
      S_MUL: begin
        opa = {2'b00, acc_hi};
        opb = acc_lo[0] ? {2'b00, mc} : '0;
        sub = 1'b0;
      end
      S_DIV: begin
        opa = {1'b0, rem, dv[DATA_W]};
        opb = {2'b00, mc};
        sub = 1'b1;
      end
      default: begin
        opa = {{2{req.left[DATA_W-1]}}, req.left};
        opb = {{2{req.right[DATA_W-1]}}, req.right};
        sub = (req.op == ALU_SUB);
      end
    endcase
    sum = opa + (sub ? ~opb : opb) + {{(DATA_W+1){1'b0}}, sub};
  end

  // saturate add/sub
  always_comb begin
    if (sum[DATA_W+1:DATA_W-1] == 3'b000 || sum[DATA_W+1:DATA_W-1] == 3'b111) begin
      addsub_res = sum[DATA_W-1:0];
    end else begin
      addsub_res = sum[DATA_W+1] ? SAT_MIN : SAT_MAX;
    end
  end

  // signed product, floor shift, saturate
  always_comb begin
    prod   = {1'b0, acc_hi, acc_lo};
    prod   = neg ? (~prod + (2*DATA_W+1)'(1)) : prod;
    prod_q = prod[2*DATA_W:FRAC_W];
    if (prod_q[DATA_W+FRAC_W:DATA_W-1] == {(FRAC_W+2){prod_q[DATA_W+FRAC_W]}}) begin
      mul_res = prod_q[DATA_W-1:0];
    end else begin
      mul_res = prod_q[DATA_W+FRAC_W] ? SAT_MIN : SAT_MAX;
    end
  end

  // apply sign to quotient, saturate
  always_comb begin
    if (ovf) begin
      div_res = neg ? SAT_MIN : SAT_MAX;
    end else if (!neg) begin
      div_res = (quo[DATA_W:DATA_W-1] != 2'b00) ? SAT_MAX : quo[DATA_W-1:0];
    end else if (quo > {2'b01, {(DATA_W-1){1'b0}}}) begin
      div_res = SAT_MIN;
    end else begin
      div_res = ~quo[DATA_W-1:0] + DATA_W'(1);
    end
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.start) begin
            op  <= req.op;
            neg <= req.left[DATA_W-1] ^ req.right[DATA_W-1];
            case (req.op)
              ALU_MUL: begin
                acc_hi <= '0;
                acc_lo <= r_mag;
                mc     <= l_mag;
                cnt    <= MUL_STEPS;
                state  <= S_MUL;
              end
              ALU_DIV: begin
                ovf   <= div_big;
                rem   <= {{(FRAC_W+1){1'b0}}, l_mag[DATA_W-1:FRAC_W+1]};
                dv    <= {l_mag[FRAC_W:0], {FRAC_W{1'b0}}};
                quo   <= '0;
                mc    <= r_mag;
                cnt   <= DIV_STEPS;
                state <= div_big ? S_FIN : S_DIV;
              end
              default: begin
                result <= addsub_res;
                done   <= 1'b1;
              end
            endcase
          end
        end
        S_MUL: begin
          acc_hi <= sum[DATA_W:1];
          acc_lo <= {sum[0], acc_lo[DATA_W-1:1]};
          cnt    <= cnt - STEP_W'(1);
          if (cnt == STEP_W'(1)) begin
            state <= S_FIN;
          end
        end
        S_DIV: begin
          if (!sum[DATA_W+1]) begin
            rem <= sum[DATA_W-1:0];
            quo <= {quo[DATA_W-1:0], 1'b1};
          end else begin
            rem <= {rem[DATA_W-2:0], dv[DATA_W]};
            quo <= {quo[DATA_W-1:0], 1'b0};
          end
          dv  <= {dv[DATA_W-1:0], 1'b0};
          cnt <= cnt - STEP_W'(1);
          if (cnt == STEP_W'(1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          result <= (op == ALU_MUL) ? mul_res : div_res;
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;

endmodule

### hw/rtl/postfix_expression_evaluator.sv
// Postfix (RPN) evaluator on signed Q16.16 words. Send one token per word:
// s_tuser is the kind, s_tdata the operand, s_tlast marks the final token.
// s_tready is high only while the sequencer is idle, so one token is in work
// at a time. Multiply and divide run bit-serially, one bit per cycle, through
// the shared arithmetic unit, except a divide whose quotient is known to
// saturate up front; each operator first passes through a state for the
// registered stack memory read. After the last token the sequencer passes
// through an end state, and one result word appears on m_tdata with its
// status on m_tuser; a result may wait on m_tready while the next
// expression's tokens are already being accepted. The top of stack sits in a
// register, the rest in a single-port-write RAM.
`include "postfix_expression_evaluator_macros.svh"

module postfix_expression_evaluator
  import pev_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // operand_value
  input  logic [KIND_W-1:0] s_tuser,   // token_kind
  input  logic              s_tlast,   // last_token
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // result_value
  output logic [STAT_W-1:0] m_tuser    // status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_WAIT,
    S_END
  } state_t;

  state_t            state;
  logic [KIND_W-1:0] kind;
  logic [DATA_W-1:0] opval;
  logic              last;
  logic [DATA_W-1:0] tos;
  logic [CNT_W-1:0]  count;
  logic [1:0]        tok_cnt;
  logic [STAT_W-1:0] err;

  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic              ram_we;
  logic [DATA_W-1:0] ram_rdata;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  state_t            after_tok;
  logic [STAT_W-1:0] fin_status;
  logic [DATA_W-1:0] fin_value;

  assign s_tready  = (state == S_IDLE);
  assign cnt_m1    = count - CNT_W'(1);
  assign cnt_m2    = count - CNT_W'(2);
  assign after_tok = last ? S_END : S_IDLE;

  // spill the old top of stack on a push
  assign ram_we = (state == S_EXEC) && (err == ST_OK) && (kind == KIND_OPERAND) &&
                  (count != '0) && (count < CNT_W'(STACK_DEPTH));

  pev_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_m1[ADDR_W-1:0]),
    .wdata (tos),
    .raddr (cnt_m2[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // operator request: left from memory, right from top of stack
  always_comb begin
    alu_req.start = (state == S_READ);
    alu_req.left  = ram_rdata;
    alu_req.right = tos;
    case (kind)
      KIND_MUL: alu_req.op = ALU_MUL;
      KIND_DIV: alu_req.op = ALU_DIV;
      KIND_ADD: alu_req.op = ALU_ADD;
      default:  alu_req.op = ALU_SUB;
    endcase
  end

  pev_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // end-of-expression status
  always_comb begin
    fin_value = '0;
    if (tok_cnt < MIN_TOKENS) begin
      fin_status = ST_SHORT;
    end else if (err != ST_OK) begin
      fin_status = err;
    end else if (count == '0) begin
      fin_status = ST_UNDER;
    end else if (count > CNT_W'(1)) begin
      fin_status = ST_LEFT;
    end else begin
      fin_status = ST_OK;
      fin_value  = tos;
    end
  end

  // token sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      tok_cnt  <= '0;
      err      <= ST_OK;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_END) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind  <= s_tuser;
            opval <= s_tdata;
            last  <= s_tlast;
            if (tok_cnt < MIN_TOKENS) begin
              tok_cnt <= tok_cnt + 2'd1;
            end
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (err != ST_OK) begin
            state <= after_tok;
          end else if (kind == KIND_OPERAND) begin
            if (count >= CNT_W'(STACK_DEPTH)) begin
              err <= ST_OVER;
            end else begin
              tos   <= opval;
              count <= count + CNT_W'(1);
            end
            state <= after_tok;
          end else if (kind > KIND_SUB) begin
            err   <= ST_BADTOK;
            state <= after_tok;
          end else if (count < CNT_W'(2)) begin
            err   <= ST_UNDER;
            state <= after_tok;
          end else if (kind == KIND_DIV && tos == '0) begin
            err   <= ST_DIVZERO;
            state <= after_tok;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            tos   <= alu_rsp.result;
            count <= cnt_m1;
            state <= after_tok;
          end
        end
        S_END: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= fin_value;
            m_tuser  <= fin_status;
            count    <= '0;
            tok_cnt  <= '0;
            err      <= ST_OK;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `PEV_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(STACK_DEPTH), "stack count past depth")
  `PEV_ASSERT_IMP(a_err_zero, m_tvalid && m_tuser != ST_OK, m_tdata == '0, "error word not zero")
  `PEV_ASSERT_IMP(a_alu_done, alu_rsp.done, state == S_WAIT, "alu done outside wait")
  `PEV_ASSERT_NXT(a_one_token, s_tvalid && s_tready, !s_tready, "token taken while busy")

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import pev_pkg::*;

  // kinds above subtract are rejected by the block
  localparam logic [KIND_W-1:0] KIND_INVALID = 3'd7;
  localparam logic [DATA_W-1:0] Q_ONE        = 32'h0001_0000;
  localparam logic [DATA_W-1:0] Q_MINUS_LSB  = 32'hffff_ffff;
  localparam longint            Q_HI         = 64'sh0000_0000_7fff_ffff;
  localparam longint            Q_LO         = -Q_HI - 1;
  localparam int                RANDOM_WORDS = 850;
  localparam int                DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] value;
    logic              last;
  } token_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [STAT_W-1:0] status;
  } rpn_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic [KIND_W-1:0] s_tuser = '0;
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic [STAT_W-1:0] m_tuser;

  postfix_expression_evaluator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  token_t      pending_tokens[$];
  token_t      expr_buf[$];
  rpn_result_t expected_results[$];
  int          tokens_total = 0;
  int          tokens_accepted = 0;
  int          mismatches = 0;

  // shadow of the evaluator state
  logic signed [DATA_W-1:0] shadow_stack [STACK_DEPTH];
  int                       shadow_depth = 0;
  int                       tokens_seen = 0;
  logic [STAT_W-1:0]        latched_status = ST_OK;

  function automatic logic [DATA_W-1:0] clamp_q16(longint v);
    if (v > Q_HI) return SAT_MAX;
    if (v < Q_LO) return SAT_MIN;
    return v[DATA_W-1:0];
  endfunction

  // apply one accepted token and queue the result it ends with, if any
  task automatic evaluate_token(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] raw,
                                input logic last);
    longint      lhs;
    longint      rhs;
    longint      wide;
    rpn_result_t res;
    if (tokens_seen < MIN_TOKENS) tokens_seen++;
    if (latched_status == ST_OK) begin
      if (kind == KIND_OPERAND) begin
        if (shadow_depth >= STACK_DEPTH) begin
          latched_status = ST_OVER;
        end else begin
          shadow_stack[shadow_depth] = raw;
          shadow_depth++;
        end
      end else if (kind > KIND_SUB) begin
        latched_status = ST_BADTOK;
      end else if (shadow_depth < 2) begin
        latched_status = ST_UNDER;
      end else begin
        rhs = shadow_stack[shadow_depth-1];
        lhs = shadow_stack[shadow_depth-2];
        if (kind == KIND_DIV && rhs == 0) begin
          latched_status = ST_DIVZERO;
        end else begin
          case (kind)
            KIND_MUL: wide = (lhs * rhs) >>> FRAC_W;
            KIND_DIV: wide = (lhs <<< FRAC_W) / rhs;
            KIND_ADD: wide = lhs + rhs;
            default:  wide = lhs - rhs;
          endcase
          shadow_depth--;
          shadow_stack[shadow_depth-1] = clamp_q16(wide);
        end
      end
    end
    if (last) begin
      res.value = '0;
      // the length check wins over any latched error
      if (tokens_seen < MIN_TOKENS) res.status = ST_SHORT;
      else if (latched_status != ST_OK) res.status = latched_status;
      else if (shadow_depth == 0) res.status = ST_UNDER;
      else if (shadow_depth > 1) res.status = ST_LEFT;
      else begin
        res.status = ST_OK;
        res.value  = shadow_stack[0];
      end
      expected_results.push_back(res);
      shadow_depth   = 0;
      tokens_seen    = 0;
      latched_status = ST_OK;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
    $display("%0t mismatch %s: expected %h got %h", $realtime, what, want, got);
    mismatches++;
  endtask

  // stimulus construction
  task automatic push_token(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] value,
                            input logic last);
    token_t t;
    t.kind  = kind;
    t.value = value;
    t.last  = last;
    pending_tokens.push_back(t);
    tokens_total++;
  endtask

  function automatic logic [DATA_W-1:0] random_operand();
    case ($urandom_range(0, 6))
      0, 1: return $urandom;
      2:    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      3:    return ($urandom_range(0, 64) - 32) << FRAC_W;
      4:    return $urandom_range(0, 511) - 256;
      5: begin
        case ($urandom_range(0, 5))
          0:       return SAT_MAX;
          1:       return SAT_MIN;
          2:       return '0;
          3:       return Q_MINUS_LSB;
          4:       return Q_ONE;
          default: return 32'd1;
        endcase
      end
      default: return $urandom | 32'h4000_0000;
    endcase
  endfunction

  // fill expr_buf with a well formed expression of the given operand count
  task automatic build_expression(input int operands, input bit deep);
    token_t t;
    int     stacked;
    int     left;
    bit     push;
    expr_buf.delete();
    stacked = 0;
    left    = operands;
    while (left > 0 || stacked > 1) begin
      if (stacked < 2 && left > 0) push = 1'b1;
      else if (left == 0 || stacked >= STACK_DEPTH) push = 1'b0;
      else if (deep) push = ($urandom_range(0, 7) != 0);
      else push = 1'($urandom_range(0, 1));
      t.last = 1'b0;
      if (push) begin
        t.kind  = KIND_OPERAND;
        t.value = random_operand();
        stacked++;
        left--;
      end else begin
        t.kind  = KIND_W'($urandom_range(KIND_MUL, KIND_SUB));
        t.value = $urandom;
        stacked--;
      end
      expr_buf.push_back(t);
    end
  endtask

  task automatic flush_expression();
    foreach (expr_buf[i]) push_token(expr_buf[i].kind, expr_buf[i].value, i == expr_buf.size() - 1);
  endtask

  // sender: bursts of words with random gaps
  int     burst_left = 1;
  int     gap_left = 0;
  token_t next_tok;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        evaluate_token(s_tuser, s_tdata, s_tlast);
        tokens_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0 || pending_tokens.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_tvalid <= 1'b0;
        end else begin
          next_tok = pending_tokens.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= next_tok.kind;
          s_tdata  <= next_tok.value;
          s_tlast  <= next_tok.last;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            // stretch with no gaps
            burst_left = $urandom_range(30, 120);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver: ready pattern switches between modes
  int   rdy_mode = 0;
  int   rdy_left = 0;
  int   rdy_cycle = 0;

  always @(posedge clk) begin
    rdy_cycle++;
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_left = $urandom_range(20, 200);
    end else begin
      rdy_left--;
    end
    case (rdy_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (rdy_cycle % 8 != 0);
    endcase
  end

  // result checker
  rpn_result_t want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", '0, m_tdata);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata !== want.value) report_mismatch("result value", want.value, m_tdata);
        if (m_tuser !== want.status) begin
          report_mismatch("status", DATA_W'(want.status), DATA_W'(m_tuser));
        end
      end
    end
  end

  // directed cases, random expressions, then drain
  initial begin
    int pick;
    int idx;
    // too short: one token, and two tokens with a bad kind
    push_token(KIND_OPERAND, Q_ONE, 1'b1);
    push_token(KIND_INVALID, '1, 1'b0);
    push_token(KIND_OPERAND, SAT_MIN, 1'b1);
    // saturating add and subtract
    push_token(KIND_OPERAND, SAT_MAX, 1'b0);
    push_token(KIND_OPERAND, 32'd1, 1'b0);
    push_token(KIND_ADD, '0, 1'b1);
    push_token(KIND_OPERAND, SAT_MIN, 1'b0);
    push_token(KIND_OPERAND, 32'd1, 1'b0);
    push_token(KIND_SUB, '1, 1'b1);
    // saturating multiply of the two most negative values
    push_token(KIND_OPERAND, SAT_MIN, 1'b0);
    push_token(KIND_OPERAND, SAT_MIN, 1'b0);
    push_token(KIND_MUL, '0, 1'b1);
    // divide of the most negative value by minus one lsb
    push_token(KIND_OPERAND, SAT_MIN, 1'b0);
    push_token(KIND_OPERAND, Q_MINUS_LSB, 1'b0);
    push_token(KIND_DIV, '0, 1'b1);
    // divide by zero
    push_token(KIND_OPERAND, Q_ONE, 1'b0);
    push_token(KIND_OPERAND, '0, 1'b0);
    push_token(KIND_DIV, '0, 1'b1);
    // operator on an empty stack, then ignored tokens
    push_token(KIND_ADD, '0, 1'b0);
    push_token(KIND_OPERAND, Q_ONE, 1'b0);
    push_token(KIND_OPERAND, Q_ONE, 1'b1);
    // leftover values
    push_token(KIND_OPERAND, 32'd1, 1'b0);
    push_token(KIND_OPERAND, 32'd2, 1'b0);
    push_token(KIND_OPERAND, 32'd3, 1'b1);
    // bad kind mid expression
    push_token(KIND_OPERAND, Q_ONE, 1'b0);
    push_token(KIND_INVALID - 3'd2, '0, 1'b0);
    push_token(KIND_OPERAND, Q_ONE, 1'b1);

    while (tokens_total < RANDOM_WORDS + 27) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        // well formed, mostly shallow, sometimes filling the stack
        if ($urandom_range(0, 9) == 0) build_expression($urandom_range(8, 17), 1'b1);
        else build_expression($urandom_range(1, 6), 1'b0);
      end else if (pick < 82) begin
        // well formed with one token dropped or its kind changed
        build_expression($urandom_range(2, 6), 1'b0);
        idx = $urandom_range(0, expr_buf.size() - 1);
        if ($urandom_range(0, 1)) expr_buf.delete(idx);
        else expr_buf[idx].kind = KIND_W'($urandom_range(0, 7));
      end else if (pick < 95) begin
        // noise
        expr_buf.delete();
        repeat ($urandom_range(1, 8)) begin
          token_t t;
          t.kind  = $urandom_range(0, 2) == 0 ? KIND_W'($urandom_range(0, 7)) : KIND_OPERAND;
          t.value = random_operand();
          t.last  = 1'b0;
          expr_buf.push_back(t);
        end
      end else begin
        // push past the stack depth, then operators
        build_expression(STACK_DEPTH + $urandom_range(1, 3), 1'b1);
        idx = expr_buf.size();
        expr_buf.delete();
        repeat (STACK_DEPTH + $urandom_range(1, 3)) begin
          token_t t;
          t.kind  = KIND_OPERAND;
          t.value = random_operand();
          t.last  = 1'b0;
          expr_buf.push_back(t);
        end
        repeat ($urandom_range(0, 3)) begin
          token_t t;
          t.kind  = KIND_W'($urandom_range(KIND_MUL, KIND_SUB));
          t.value = '0;
          t.last  = 1'b0;
          expr_buf.push_back(t);
        end
      end
      flush_expression();
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (tokens_accepted < tokens_total || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS postfix_expression_evaluator");
    end else begin
      $display("FAIL postfix_expression_evaluator");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("FAIL postfix_expression_evaluator");
    $finish;
  end

endmodule
